### src/nssd_pkg.sv
// ----------------------------------------------------------------------------
// nssd_pkg
// Shared constants and types for the sentence decoder: character codes,
// status / error / sentence type codes, and the decoder mode encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package nssd_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 32;
  localparam int SUM_DIGITS          = 2;
  localparam int FIELD_W             = 16;
  localparam int FIELD_CNT           = 3;
  localparam int COUNT_W             = 6;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_F = 8'd70;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_V = 8'h56;

  typedef enum logic [1:0] {
    STATUS_ACCEPT  = 2'd0,
    STATUS_DECODED = 2'd1,
    STATUS_ERROR   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OUTSIDE   = 3'd1,
    ERR_BAD_CHAR  = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_UNKNOWN   = 3'd4,
    ERR_CHECKSUM  = 3'd5
  } err_kind_t;

  typedef enum logic [2:0] {
    TYPE_NONE = 3'd0,
    TYPE_CHA  = 3'd1,
    TYPE_ACC  = 3'd2,
    TYPE_REV  = 3'd3,
    TYPE_SHO  = 3'd4,
    TYPE_RES  = 3'd5
  } msg_type_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_PAYLOAD = 3'b010,
    MODE_SUM     = 3'b100
  } mode_t;

  function automatic msg_type_t classify(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
    msg_type_t t;
    t = TYPE_NONE;
    if (a == CH_C && b == CH_H && c == CH_A) t = TYPE_CHA;
    else if (a == CH_A && b == CH_C && c == CH_C) t = TYPE_ACC;
    else if (a == CH_R && b == CH_E && c == CH_V) t = TYPE_REV;
    else if (a == CH_S && b == CH_H && c == CH_O) t = TYPE_SHO;
    else if (a == CH_R && b == CH_E && c == CH_S) t = TYPE_RES;
    return t;
  endfunction

endpackage

`default_nettype wire

### src/nssd_if.sv
// ----------------------------------------------------------------------------
// nssd_if
// Valid/ready channels of the sentence decoder: the received byte stream and
// the per-byte status stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface nssd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface nssd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  error_kind;
  logic [2:0]  message_type;
  logic [15:0] field_a;
  logic [15:0] field_b;
  logic [15:0] field_c;

  modport source (output valid, output status, output error_kind, output message_type,
                  output field_a, output field_b, output field_c, input ready);
  modport sink   (input valid, input status, input error_kind, input message_type,
                  input field_a, input field_b, input field_c, output ready);
endinterface

`default_nettype wire

### src/nmea_style_sentence_decoder.sv
// ----------------------------------------------------------------------------
// nmea_style_sentence_decoder
// Byte-serial deframer for $TTT,n,n,n*HH<LF> sentences with XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   chars   : one received ASCII byte per transfer (valid/ready).
//   results : one status per byte, in order: accepted, decoded (with type
//             and up to three decimal fields) or error (with its kind).
//   A byte is held in an input register, decoded against the sentence state
//   by one pass of logic, and the status lands in an output register. The
//   status register loads from the input register as the byte advances,
//   so each status passes the input and then the output register. One
//   byte per cycle is sustained while results.ready stays high; the pass
//   that updates the sentence registers sets that figure.
//   If the results receiver stalls, the output register holds its status,
//   the input register holds one more byte, and chars.ready then drops.
//   Reset (rst, synchronous) empties both registers and returns the decoder
//   to idle, waiting for '$'. Any error also returns it to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_style_sentence_decoder
  import nssd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  nssd_byte_if.sink         chars,
  nssd_result_if.source     results
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  // sentence state
  mode_t                  mode, mode_next;
  logic [7:0]             running_xor, running_xor_next;
  logic [COUNT_W-1:0]     payload_count, payload_count_next;
  logic [15:0]            type_letters, type_letters_next;
  msg_type_t              type_code, type_code_next;
  logic [1:0]             field_index, field_index_next;
  logic [FIELD_W-1:0]     field_values [FIELD_CNT];
  logic [FIELD_W-1:0]     field_values_next [FIELD_CNT];
  logic [1:0]             hex_count, hex_count_next;
  logic [7:0]             received_sum, received_sum_next;

  // output register
  logic                   out_full;
  status_t                r_status;
  err_kind_t              r_err;
  msg_type_t              r_type;
  logic [FIELD_W-1:0]     r_fa, r_fb, r_fc;

  logic      advance;
  logic      err_hit;
  err_kind_t err_code;
  logic      decoded;
  logic      is_dig, is_up, is_hex;
  logic [3:0] nib;
  logic [FIELD_W+3:0] acc [FIELD_CNT];

  assign advance     = in_full && (!out_full || results.ready);
  assign chars.ready = !in_full || advance;

  assign is_dig = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_up  = (in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_Z);
  assign is_hex = is_dig || ((in_byte >= CH_UPPER_A) && (in_byte <= CH_UPPER_F));
  assign nib    = is_dig ? in_byte[3:0] : in_byte[3:0] + 4'd9;

  always_comb begin
    for (int k = 0; k < FIELD_CNT; k++) begin
      acc[k] = (20'(field_values[k]) * 20'd10) + 20'(in_byte[3:0]);
    end
  end

  always_comb begin
    mode_next          = mode;
    running_xor_next   = running_xor;
    payload_count_next = payload_count;
    type_letters_next  = type_letters;
    type_code_next     = type_code;
    field_index_next   = field_index;
    for (int k = 0; k < FIELD_CNT; k++) field_values_next[k] = field_values[k];
    hex_count_next     = hex_count;
    received_sum_next  = received_sum;
    err_hit            = 1'b0;
    err_code           = ERR_NONE;
    decoded            = 1'b0;

    unique case (mode)
      MODE_PAYLOAD: begin
        if (in_byte == CH_STAR) begin
          mode_next = MODE_SUM;
        end else if (!(is_up || is_dig || in_byte == CH_COMMA)) begin
          err_hit  = 1'b1;
          err_code = ERR_BAD_CHAR;
        end else if (payload_count >= COUNT_W'(MAX_PAYLOAD)) begin
          err_hit  = 1'b1;
          err_code = ERR_TOO_LONG;
        end else begin
          if (payload_count < COUNT_W'(2)) begin
            type_letters_next = {type_letters[7:0], in_byte};
          end else if (payload_count == COUNT_W'(2)) begin
            type_code_next = classify(type_letters[15:8], type_letters[7:0], in_byte);
          end
          if (in_byte == CH_COMMA) begin
            if (field_index == 2'd3) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_CHAR;
            end else begin
              field_index_next   = field_index + 2'd1;
              payload_count_next = payload_count + COUNT_W'(1);
            end
          end else begin
            running_xor_next   = running_xor ^ in_byte;
            payload_count_next = payload_count + COUNT_W'(1);
            // digits before the first comma only feed the checksum
            if (is_dig) begin
              for (int k = 0; k < FIELD_CNT; k++) begin
                if (field_index == 2'(k + 1)) begin
                  field_values_next[k] = (acc[k] > 20'hFFFF) ? 16'hFFFF : acc[k][15:0];
                end
              end
            end
          end
        end
      end
      MODE_SUM: begin
        if (in_byte == CH_NEWLINE) begin
          if (type_code == TYPE_NONE) begin
            err_hit  = 1'b1;
            err_code = ERR_UNKNOWN;
          end else if (hex_count < 2'(SUM_DIGITS) || received_sum != running_xor) begin
            err_hit  = 1'b1;
            err_code = ERR_CHECKSUM;
          end else begin
            decoded   = 1'b1;
            mode_next = MODE_IDLE;
          end
        end else if (!is_hex) begin
          err_hit  = 1'b1;
          err_code = ERR_BAD_CHAR;
        end else if (hex_count >= 2'(SUM_DIGITS)) begin
          err_hit  = 1'b1;
          err_code = ERR_TOO_LONG;
        end else begin
          received_sum_next = {received_sum[3:0], nib};
          hex_count_next    = hex_count + 2'd1;
        end
      end
      default: begin
        // idle, and any stray encoding behaves as idle
        if (in_byte != CH_DOLLAR) begin
          err_hit  = 1'b1;
          err_code = ERR_OUTSIDE;
        end else begin
          mode_next          = MODE_PAYLOAD;
          running_xor_next   = '0;
          payload_count_next = '0;
          type_letters_next  = '0;
          type_code_next     = TYPE_NONE;
          field_index_next   = '0;
          for (int k = 0; k < FIELD_CNT; k++) field_values_next[k] = '0;
          hex_count_next     = '0;
          received_sum_next  = '0;
        end
      end
    endcase

    if (err_hit) mode_next = MODE_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (chars.valid && chars.ready) begin
      in_byte <= chars.byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      running_xor   <= '0;
      payload_count <= '0;
      type_letters  <= '0;
      type_code     <= TYPE_NONE;
      field_index   <= '0;
      for (int k = 0; k < FIELD_CNT; k++) field_values[k] <= '0;
      hex_count     <= '0;
      received_sum  <= '0;
    end else if (advance) begin
      mode          <= mode_next;
      running_xor   <= running_xor_next;
      payload_count <= payload_count_next;
      type_letters  <= type_letters_next;
      type_code     <= type_code_next;
      field_index   <= field_index_next;
      for (int k = 0; k < FIELD_CNT; k++) field_values[k] <= field_values_next[k];
      hex_count     <= hex_count_next;
      received_sum  <= received_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (results.ready) begin
      out_full <= 1'b0;
    end
    if (advance) begin
      r_status <= err_hit ? STATUS_ERROR : (decoded ? STATUS_DECODED : STATUS_ACCEPT);
      r_err    <= err_code;
      r_type   <= decoded ? type_code : TYPE_NONE;
      r_fa     <= decoded ? field_values[0] : '0;
      r_fb     <= (decoded && (type_code == TYPE_SHO || type_code == TYPE_RES))
                  ? field_values[1] : '0;
      r_fc     <= (decoded && type_code == TYPE_RES) ? field_values[2] : '0;
    end
  end

  assign results.valid        = out_full;
  assign results.status       = r_status;
  assign results.error_kind   = r_err;
  assign results.message_type = r_type;
  assign results.field_a      = r_fa;
  assign results.field_b      = r_fb;
  assign results.field_c      = r_fc;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Byte stream test of the sentence decoder. Bytes are pushed one at a time
// and each transfer is run through a local decoder model. The status stream
// is checked in order against the model: directed frames first (every type,
// framing faults, length and checksum faults), then random traffic with
// mostly well-formed sentences under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module testbench;
  import nssd_pkg::*;

  localparam int         QUIET_LIMIT = 2000;
  localparam logic [7:0] CH_RETURN   = 8'h0D;
  localparam int         FIELD_SAT   = 65535;

  typedef logic [7:0] char_q_t [$];

  typedef struct {
    status_t     status;
    err_kind_t   error_kind;
    msg_type_t   message_type;
    logic [15:0] field_a;
    logic [15:0] field_b;
    logic [15:0] field_c;
  } sentence_result_t;

  logic clk;
  logic rst;

  nssd_byte_if   char_ch ();
  nssd_result_if status_ch ();

  nmea_style_sentence_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_ch),
    .results (status_ch)
  );

  // decoder model state
  mode_t       dec_mode = MODE_IDLE;
  logic [7:0]  dec_xor = '0;
  int unsigned dec_count = 0;
  logic [15:0] dec_letters = '0;
  msg_type_t   dec_type = TYPE_NONE;
  int unsigned dec_commas = 0;
  int unsigned dec_fields [FIELD_CNT] = '{default: 0};
  int unsigned dec_hex_count = 0;
  logic [7:0]  dec_sum = '0;

  sentence_result_t expected_status_q [$];
  sentence_result_t oldest_status;

  string type_names [5] = '{"CHA", "ACC", "REV", "SHO", "RES"};

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic msg_type_t type_of(input logic [23:0] letters);
    case (letters)
      {CH_C, CH_H, CH_A}: return TYPE_CHA;
      {CH_A, CH_C, CH_C}: return TYPE_ACC;
      {CH_R, CH_E, CH_V}: return TYPE_REV;
      {CH_S, CH_H, CH_O}: return TYPE_SHO;
      {CH_R, CH_E, CH_S}: return TYPE_RES;
      default:            return TYPE_NONE;
    endcase
  endfunction

  // any error drops the decoder back to idle
  function automatic sentence_result_t plain_status(input status_t s, input err_kind_t e);
    sentence_result_t r;
    r = '{status: s, error_kind: e, message_type: TYPE_NONE,
          field_a: '0, field_b: '0, field_c: '0};
    if (s == STATUS_ERROR) dec_mode = MODE_IDLE;
    return r;
  endfunction

  function automatic sentence_result_t predict_status(input logic [7:0] c);
    sentence_result_t r;
    int unsigned v;
    int unsigned nib;
    case (dec_mode)
      MODE_PAYLOAD: begin
        if (c == CH_STAR) begin
          dec_mode = MODE_SUM;
          return plain_status(STATUS_ACCEPT, ERR_NONE);
        end
        if (!((c >= CH_UPPER_A && c <= CH_UPPER_Z) || is_digit(c) || c == CH_COMMA))
          return plain_status(STATUS_ERROR, ERR_BAD_CHAR);
        if (dec_count >= MAX_PAYLOAD_DEFAULT) return plain_status(STATUS_ERROR, ERR_TOO_LONG);
        // type comes from payload positions 0..2, commas included
        if (dec_count < 2) dec_letters = {dec_letters[7:0], c};
        else if (dec_count == 2) dec_type = type_of({dec_letters, c});
        if (c == CH_COMMA) begin
          if (dec_commas >= FIELD_CNT) return plain_status(STATUS_ERROR, ERR_BAD_CHAR);
          dec_commas++;
        end else begin
          dec_xor ^= c;
          if (is_digit(c) && dec_commas >= 1) begin
            v = dec_fields[dec_commas - 1] * 10 + (c - CH_ZERO);
            dec_fields[dec_commas - 1] = (v > FIELD_SAT) ? FIELD_SAT : v;
          end
        end
        dec_count++;
        return plain_status(STATUS_ACCEPT, ERR_NONE);
      end
      MODE_SUM: begin
        if (c == CH_NEWLINE) begin
          if (dec_type == TYPE_NONE) return plain_status(STATUS_ERROR, ERR_UNKNOWN);
          if (dec_hex_count < SUM_DIGITS || dec_sum != dec_xor)
            return plain_status(STATUS_ERROR, ERR_CHECKSUM);
          r = plain_status(STATUS_DECODED, ERR_NONE);
          r.message_type = dec_type;
          r.field_a = 16'(dec_fields[0]);
          if (dec_type == TYPE_SHO || dec_type == TYPE_RES) r.field_b = 16'(dec_fields[1]);
          if (dec_type == TYPE_RES) r.field_c = 16'(dec_fields[2]);
          dec_mode = MODE_IDLE;
          return r;
        end
        if (is_digit(c)) nib = c - CH_ZERO;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) nib = c - CH_UPPER_A + 10;
        else return plain_status(STATUS_ERROR, ERR_BAD_CHAR);
        if (dec_hex_count >= SUM_DIGITS) return plain_status(STATUS_ERROR, ERR_TOO_LONG);
        dec_sum = {dec_sum[3:0], nib[3:0]};
        dec_hex_count++;
        return plain_status(STATUS_ACCEPT, ERR_NONE);
      end
      default: begin
        if (c != CH_DOLLAR) return plain_status(STATUS_ERROR, ERR_OUTSIDE);
        dec_xor = '0;
        dec_count = 0;
        dec_letters = '0;
        dec_type = TYPE_NONE;
        dec_commas = 0;
        dec_fields = '{default: 0};
        dec_hex_count = 0;
        dec_sum = '0;
        dec_mode = MODE_PAYLOAD;
        return plain_status(STATUS_ACCEPT, ERR_NONE);
      end
    endcase
  endfunction

  // --- stimulus helpers -----------------------------------------------------

  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(99) < tx_idle_pct) begin
      char_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    char_ch.valid   <= 1'b1;
    char_ch.byte_in <= c;
    do @(posedge clk); while (char_ch.ready !== 1'b1);
    expected_status_q.push_back(predict_status(c));
    bytes_sent++;
  endtask

  task automatic send_q(input char_q_t q);
    foreach (q[i]) send_char(q[i]);
  endtask

  function automatic char_q_t chars_of(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_text(input string s);
    send_q(chars_of(s));
  endtask

  function automatic logic [7:0] body_xor(input char_q_t body);
    logic [7:0] x;
    x = '0;
    foreach (body[i]) if (body[i] != CH_COMMA) x ^= body[i];
    return x;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_ZERO + 8'(n) : CH_UPPER_A + 8'(n) - 8'd10;
  endfunction

  // '$' body '*' then digits hex characters of sum (low nibble last) and newline
  task automatic send_frame(input char_q_t body, input int digits, input logic [7:0] sum);
    send_char(CH_DOLLAR);
    send_q(body);
    send_char(CH_STAR);
    for (int i = digits; i > 0; i--) send_char(hex_char((i % 2 == 0) ? sum[7:4] : sum[3:0]));
    send_char(CH_NEWLINE);
  endtask

  task automatic send_sentence(input string s);
    send_frame(chars_of(s), SUM_DIGITS, body_xor(chars_of(s)));
  endtask

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] random_letter();
    return CH_UPPER_A + 8'($urandom_range(25));
  endfunction

  function automatic char_q_t random_body();
    char_q_t b;
    string   name;
    int      len;
    name = type_names[$urandom_range(4)];
    for (int i = 0; i < 3; i++) b.push_back(name[i]);
    if ($urandom_range(9) == 0) b[$urandom_range(2)] = random_letter();
    if ($urandom_range(19) == 0) repeat ($urandom_range(1, 3)) void'(b.pop_back());
    if ($urandom_range(7) == 0) b.push_back(random_digit());
    repeat ($urandom_range(3)) begin
      b.push_back(CH_COMMA);
      len = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
      repeat (len) b.push_back(($urandom_range(15) == 0) ? random_letter() : random_digit());
    end
    return b;
  endfunction

  // --- status checking ------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && status_ch.valid && status_ch.ready) begin
      if (expected_status_q.size() == 0) begin
        $error("status transfer with none pending: status %0d", status_ch.status);
        fail_count++;
      end else begin
        oldest_status = expected_status_q.pop_front();
        check_field("status", oldest_status.status, status_ch.status);
        check_field("error_kind", oldest_status.error_kind, status_ch.error_kind);
        check_field("message_type", oldest_status.message_type, status_ch.message_type);
        check_field("field_a", oldest_status.field_a, status_ch.field_a);
        check_field("field_b", oldest_status.field_b, status_ch.field_b);
        check_field("field_c", oldest_status.field_c, status_ch.field_c);
      end
    end
  end

  always @(posedge clk) status_ch.ready <= ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk) begin
    if ((char_ch.valid && char_ch.ready) || (status_ch.valid && status_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transfer for %0d cycles, %0d statuses pending", quiet_cycles,
             expected_status_q.size());
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --- tests ----------------------------------------------------------------

  task automatic test_outside_sentence();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_STAR);
    send_char(CH_NEWLINE);
  endtask

  task automatic test_sentence_types();
    send_sentence("CHA,65535");
    send_sentence("ACC,0");
    send_sentence("REV,4095");
    send_sentence("SHO,9,99999");
    // digit ahead of the first comma is hashed but not a field
    send_sentence("RES7,1,20,300");
  endtask

  task automatic test_bad_characters();
    send_text("$CHa");
    send_char(CH_DOLLAR);
    send_char(CH_RETURN);
    send_text("$AC$");
    send_text("$ACC,1,2,3,");
    send_text("$CHA*1G");
  endtask

  task automatic test_length_limits();
    // full-length payload decodes, one more byte overflows
    send_sentence("CHA,9876543210987654321098765432");
    send_char(CH_DOLLAR);
    repeat (MAX_PAYLOAD_DEFAULT + 1) send_char(CH_NINE);
    send_frame(chars_of("ACC,3"), SUM_DIGITS + 1, body_xor(chars_of("ACC,3")));
  endtask

  task automatic test_unknown_type();
    send_sentence("XYZ,1");
    send_sentence("CH");
    send_sentence("");
  endtask

  task automatic test_checksum();
    send_frame(chars_of("REV,5"), SUM_DIGITS, body_xor(chars_of("REV,5")) ^ 8'h80);
    send_frame(chars_of("REV,5"), 1, body_xor(chars_of("REV,5")));
    send_frame(chars_of("REV,5"), 0, body_xor(chars_of("REV,5")));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    int          stop_at;
    int          pick;
    char_q_t     body;
    logic [7:0]  sum;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      body = random_body();
      sum  = body_xor(body);
      if (pick < 70) begin
        send_frame(body, SUM_DIGITS, sum);
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
      end else if (pick < 86) begin
        // stray byte dropped into an otherwise good sentence
        body.insert($urandom_range(body.size()), 8'($urandom_range(255)));
        send_frame(body, SUM_DIGITS, sum);
      end else if (pick < 92) begin
        case ($urandom_range(3))
          0: send_frame(body, SUM_DIGITS, sum ^ (8'h01 << $urandom_range(7)));
          1: send_frame(body, $urandom_range(1), sum);
          2: send_frame(body, SUM_DIGITS + 1, sum);
          default: begin
            send_char(CH_DOLLAR);
            send_q(body);
            send_char(CH_STAR);
            send_char(($urandom_range(1) == 0) ? CH_RETURN : 8'($urandom_range(255)));
            send_char(CH_NEWLINE);
          end
        endcase
      end else if (pick < 96) begin
        send_char(CH_DOLLAR);
        repeat (MAX_PAYLOAD_DEFAULT + $urandom_range(1, 2))
          send_char(($urandom_range(1) == 0) ? random_digit() : random_letter());
        send_char(CH_STAR);
      end else begin
        body = chars_of(type_names[$urandom_range(4)]);
        repeat (FIELD_CNT + 1) begin
          body.push_back(CH_COMMA);
          body.push_back(random_digit());
        end
        send_frame(body, SUM_DIGITS, body_xor(body));
      end
    end
  endtask

  initial begin
    rst             <= 1'b1;
    char_ch.valid   <= 1'b0;
    char_ch.byte_in <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_outside_sentence();
    test_sentence_types();
    test_bad_characters();
    test_length_limits();
    test_unknown_type();
    test_checksum();
    test_random_traffic(0, 0, 405);
    test_random_traffic(55, 0, 400);
    test_random_traffic(0, 55, 400);
    test_random_traffic(25, 25, 410);

    char_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
